[sv/pdh_pkg.sv]
// shared types and constants for the pair distance histogram
package pdh_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned BIN_W = 6;
  localparam int unsigned COUNT_W = 20;
  localparam int unsigned BWID_W = 16;
  localparam int unsigned DIST_W = 18;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [BWID_W-1:0] BWID_RESET = 16'd1448;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } pos_t;

  typedef struct packed {
    cmd_t cmd;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [COUNT_W-1:0] pair_count;
    logic last_bin;
    logic dropped;
  } out_item_t;

endpackage

[sv/pdh_ram.sv]
// generic single port write, single port registered read memory
module pdh_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/pdh_sqrt_cell.sv]
// one cell of the square root chain: retires one root bit per cycle
module pdh_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                        clk,
  input  logic                        vld_in,
  input  logic [2*pdh_pkg::DIST_W-1:0] rem_in,
  input  logic [pdh_pkg::DIST_W-1:0]  root_in,
  output logic                        vld_out,
  output logic [2*pdh_pkg::DIST_W-1:0] rem_out,
  output logic [pdh_pkg::DIST_W-1:0]  root_out,
  input  logic                        rst_n
);

  localparam int unsigned DW = pdh_pkg::DIST_W;
  localparam int unsigned RB = DW - 1 - STEP;

  // rem holds radicand minus root squared; adding bit RB to the root costs
  // 2 * root * 2^RB + 2^(2*RB), and the two terms never overlap
  logic [2*DW-1:0] trial;
  logic fits;

  always_comb begin
    trial = ((2*DW)'(root_in) << (RB + 1)) | ((2*DW)'(1) << (2 * RB));
    fits = (rem_in >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
    rem_out <= fits ? rem_in - trial : rem_in;
    root_out <= fits ? (root_in | (DW'(1) << RB)) : root_in;
  end

endmodule

[sv/pair_distance_histogram.sv]
// top level of the pair distance histogram
// A load transaction stores one 3-D position and compares it with the n positions
// already stored, one pair a cycle, stalling the input through the scan and the drain
// of the per-pair pipeline; there is no scan when the store is empty or full. A finish
// transaction emits NUM_BINS results, each bin taking ST_EMIT and ST_EMIT_OUT
// plus any output stall, and zeroes each bin as it is read; the fill count and drop
// flag clear with the last bin. After reset a clearing pass over every bin zeroes the
// histogram memory while the input is stalled. The rate is set by the single memory
// read port walking the stored positions and the chained per-pair pipeline behind it
// (square root cells, one bit each, then a divide by bin width, one bit a cycle, in
// cells of its own, then a read-modify-write of the histogram memory). Stored
// positions are not cleared; only the fill count is.
module pair_distance_histogram #(
  parameter int unsigned MAX_PARTICLES = 1024,
  parameter int unsigned NUM_BINS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pdh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pdh_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [pdh_pkg::BWID_W-1:0] cfg_data
);

  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned DW = pdh_pkg::DIST_W;
  localparam int unsigned BW = pdh_pkg::BIN_W;
  localparam int unsigned WW = pdh_pkg::BWID_W;
  localparam int unsigned CNW = pdh_pkg::COUNT_W;
  localparam int unsigned SQ_LAT = DW;
  localparam int unsigned DIV_LAT = DW;
  localparam int unsigned DRAIN = SQ_LAT + DIV_LAT + 6;
  localparam int unsigned DRW = $clog2(DRAIN + 1);
  localparam int unsigned NBW = $clog2(NUM_BINS);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_SCAN, ST_DRAIN, ST_EMIT, ST_EMIT_OUT
  } state_t;

  state_t state_r;
  logic [WW-1:0] bwid_r;
  logic [CW-1:0] pcount_r;
  logic drop_r;
  logic [CW-1:0] scan_r;
  logic [DRW-1:0] drain_r;
  logic [NBW-1:0] emit_r;
  pdh_pkg::pos_t newpos_r;
  logic ov_r;
  pdh_pkg::out_item_t out_r;

  // bin width only changes while nothing is in flight
  assign cfg_ready = (state_r == ST_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bwid_r <= pdh_pkg::BWID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bwid_r <= cfg_data;
    end
  end

  // position memory
  logic ram_we;
  logic [AW-1:0] ram_rd_addr;
  pdh_pkg::pos_t ram_q;
  pdh_pkg::pos_t in_pos;
  assign in_pos = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
  assign ram_rd_addr = scan_r[AW-1:0];

  pdh_ram #(.WIDTH($bits(pdh_pkg::pos_t)), .DEPTH(MAX_PARTICLES)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(pcount_r[AW-1:0]), .wr_data(in_pos),
    .rd_addr(ram_rd_addr), .rd_data(ram_q)
  );

  logic in_acc;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  logic full;
  assign full = (pcount_r == CW'(MAX_PARTICLES));
  assign ram_we = in_acc && (in_data.cmd == pdh_pkg::CMD_LOAD) && !full;

  // the read data and rd_vld_r are both registered from the address, so they line up
  logic rd_vld_r;
  logic sq_vld_r;
  logic [2*DW-1:0] sum_r;
  logic sum_vld_r;

  logic [DW-1:0] dx, dy, dz;
  assign dx = DW'((ram_q.x >= newpos_r.x) ? ram_q.x - newpos_r.x : newpos_r.x - ram_q.x);
  assign dy = DW'((ram_q.y >= newpos_r.y) ? ram_q.y - newpos_r.y : newpos_r.y - ram_q.y);
  assign dz = DW'((ram_q.z >= newpos_r.z) ? ram_q.z - newpos_r.z : newpos_r.z - ram_q.z);

  logic [2:0][2*DW-1:0] prod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      sum_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= rd_vld_r;
      sum_vld_r <= sq_vld_r;
    end
    prod_r[0] <= (2*DW)'(dx) * (2*DW)'(dx);
    prod_r[1] <= (2*DW)'(dy) * (2*DW)'(dy);
    prod_r[2] <= (2*DW)'(dz) * (2*DW)'(dz);
    sum_r <= prod_r[0] + prod_r[1] + prod_r[2];
  end

  // square root chain
  logic [SQ_LAT:0] sv;
  logic [SQ_LAT:0][2*DW-1:0] srem;
  logic [SQ_LAT:0][DW-1:0] sroot;
  assign sv[0] = sum_vld_r;
  assign srem[0] = sum_r;
  assign sroot[0] = '0;
  for (genvar g = 0; g < SQ_LAT; g++) begin : g_sq
    pdh_sqrt_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .vld_in(sv[g]), .rem_in(srem[g]), .root_in(sroot[g]),
      .vld_out(sv[g+1]), .rem_out(srem[g+1]), .root_out(sroot[g+1])
    );
  end

  // restoring divide chain, one quotient bit per cell
  logic [WW-1:0] wdiv;
  assign wdiv = (bwid_r == '0) ? WW'(1) : bwid_r;
  logic [DIV_LAT:0] dv;
  logic [DIV_LAT:0][DW-1:0] dnum;
  logic [DIV_LAT:0][DW:0] drem;
  logic [DIV_LAT:0][DW-1:0] dquo;
  assign dv[0] = sv[SQ_LAT];
  assign dnum[0] = sroot[SQ_LAT];
  assign drem[0] = '0;
  assign dquo[0] = '0;
  for (genvar g = 0; g < DIV_LAT; g++) begin : g_div
    logic [DW:0] sh;
    logic ge;
    assign sh = {drem[g][DW-1:0], dnum[g][DW-1-g]};
    assign ge = (sh >= (DW+1)'(wdiv));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv[g+1] <= 1'b0;
      end else begin
        dv[g+1] <= dv[g];
      end
      dnum[g+1] <= dnum[g];
      drem[g+1] <= ge ? sh - (DW+1)'(wdiv) : sh;
      dquo[g+1] <= {dquo[g][DW-2:0], ge};
    end
  end

  // distances past the last bin land in it
  logic [NBW-1:0] bin_sel;
  assign bin_sel = (dquo[DIV_LAT] > DW'(NUM_BINS - 1)) ? NBW'(NUM_BINS - 1)
                                                       : NBW'(dquo[DIV_LAT]);

  logic out_take;
  assign out_take = out_valid && !out_stall;
  assign out_valid = ov_r;
  assign out_data = out_r;

  // a bin is handed to the output register once it is free or draining
  logic emit_load;
  assign emit_load = (state_r == ST_EMIT_OUT) && (!ov_r || out_take);

  // histogram memory: read the bin, add one to the registered read data, write it back
  logic hist_we;
  logic [NBW-1:0] hist_wa;
  logic [NBW-1:0] hist_ra;
  logic [CNW-1:0] hist_wd;
  logic [CNW-1:0] hist_q;
  logic upd_vld_r;
  logic [NBW-1:0] upd_bin_r;
  logic fwd_vld_r;
  logic [NBW-1:0] fwd_bin_r;
  logic [CNW-1:0] fwd_cnt_r;
  logic [CNW-1:0] upd_cur;
  logic [CNW-1:0] upd_cnt;

  assign hist_ra = (state_r == ST_EMIT || state_r == ST_EMIT_OUT) ? emit_r : bin_sel;

  // the write issued on the read edge is not yet in the read data, so bypass it
  assign upd_cur = (fwd_vld_r && fwd_bin_r == upd_bin_r) ? fwd_cnt_r : hist_q;
  assign upd_cnt = (upd_cur == pdh_pkg::COUNT_MAX) ? upd_cur : upd_cur + 1'b1;

  always_comb begin
    hist_we = 1'b0;
    hist_wa = upd_bin_r;
    hist_wd = upd_cnt;
    if (state_r == ST_INIT || emit_load) begin
      // clearing pass after reset, or zero each bin as it is emitted
      hist_we = 1'b1;
      hist_wa = emit_r;
      hist_wd = '0;
    end else if (upd_vld_r) begin
      hist_we = 1'b1;
    end
  end

  pdh_ram #(.WIDTH(CNW), .DEPTH(NUM_BINS)) u_hist (
    .clk(clk), .wr_en(hist_we), .wr_addr(hist_wa), .wr_data(hist_wd),
    .rd_addr(hist_ra), .rd_data(hist_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_vld_r <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      upd_vld_r <= dv[DIV_LAT];
      fwd_vld_r <= upd_vld_r;
    end
    upd_bin_r <= bin_sel;
    fwd_bin_r <= upd_bin_r;
    fwd_cnt_r <= upd_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      pcount_r <= '0;
      drop_r <= 1'b0;
      scan_r <= '0;
      drain_r <= '0;
      emit_r <= '0;
      rd_vld_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_SCAN);
      ov_r <= emit_load || (ov_r && !out_take);
      case (state_r)
        ST_INIT: begin
          if (emit_r == NBW'(NUM_BINS - 1)) begin
            emit_r <= '0;
            state_r <= ST_IDLE;
          end else begin
            emit_r <= emit_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.cmd == pdh_pkg::CMD_FINISH) begin
              state_r <= ST_EMIT;
              emit_r <= '0;
            end else if (full) begin
              drop_r <= 1'b1;
            end else begin
              newpos_r <= in_pos;
              pcount_r <= pcount_r + 1'b1;
              scan_r <= '0;
              state_r <= (pcount_r == '0) ? ST_IDLE : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // the new entry sits at pcount_r - 1 and is not compared
          if (scan_r == pcount_r - 2'd2) begin
            state_r <= ST_DRAIN;
            drain_r <= '0;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (drain_r == DRW'(DRAIN)) state_r <= ST_IDLE;
        end
        ST_EMIT: begin
          // read address goes out, count is back next cycle
          state_r <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (emit_load) begin
            out_r.bin_index <= BW'(emit_r);
            out_r.pair_count <= hist_q;
            out_r.last_bin <= (emit_r == NBW'(NUM_BINS - 1));
            out_r.dropped <= drop_r;
            if (emit_r == NBW'(NUM_BINS - 1)) begin
              emit_r <= '0;
              pcount_r <= '0;
              drop_r <= 1'b0;
              state_r <= ST_IDLE;
            end else begin
              emit_r <= emit_r + 1'b1;
              state_r <= ST_EMIT;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
